/* hw/rtl/artdmx_pkg.sv */
// ----------------------------------------------------------------------------
// artdmx_pkg
// Shared types, opcodes, status codes and the header text for the ArtDmx
// receiver.
// ----------------------------------------------------------------------------
package artdmx_pkg;

    // Default sizing handed to the top level
    localparam int ARTDMX_MAX_LIGHTS       = 16;
    localparam int ARTDMX_MAX_PACKET_BYTES = 1024;

    // Opcode low bytes
    localparam logic [7:0] OPC_POLL        = 8'h20;
    localparam logic [7:0] OPC_POLL_REPLY  = 8'h21;
    localparam logic [7:0] OPC_DMX         = 8'h50;
    localparam logic [7:0] OPC_TOD_REQUEST = 8'h80;
    localparam logic [7:0] PROTO_VERSION   = 8'd14;

    // Packet status codes
    localparam logic [3:0] ST_DMX_APPLIED  = 4'd0;
    localparam logic [3:0] ST_POLL         = 4'd1;
    localparam logic [3:0] ST_TOD_REQUEST  = 4'd2;
    localparam logic [3:0] ST_POLL_REPLY   = 4'd3;
    localparam logic [3:0] ST_BAD_MAGIC    = 4'd4;
    localparam logic [3:0] ST_BAD_OPCODE   = 4'd5;
    localparam logic [3:0] ST_UNKNOWN_OPC  = 4'd6;
    localparam logic [3:0] ST_WRONG_VER    = 4'd7;
    localparam logic [3:0] ST_TOO_SHORT    = 4'd8;

    // One payload byte
    typedef struct packed {
        logic [7:0] data_byte;
        logic       end_of_packet;
    } t_in_item;

    // One result
    typedef struct packed {
        logic        result_is_status;
        logic [3:0]  status_code;
        logic [3:0]  light_index;
        logic [15:0] red_level;
        logic [15:0] green_level;
        logic [15:0] blue_level;
        logic        last_of_run;
    } t_out_item;

    // Parser handshake toward the input and output registers
    typedef struct packed {
        logic load;     // a result goes into the output register
        logic consume;  // the registered byte is finished
    } t_step;

    // Expected header text, zero terminated
    function automatic logic [7:0] magic_byte(input logic [2:0] idx);
        logic [7:0] ch;
        unique case (idx)
            3'd0:    ch = 8'h41;
            3'd1:    ch = 8'h72;
            3'd2:    ch = 8'h74;
            3'd3:    ch = 8'h2D;
            3'd4:    ch = 8'h4E;
            3'd5:    ch = 8'h65;
            3'd6:    ch = 8'h74;
            default: ch = 8'h00;
        endcase
        return ch;
    endfunction

endpackage

/* hw/rtl/artdmx_parser.sv */
// ----------------------------------------------------------------------------
// artdmx_parser
// Per-packet header checks, channel limit, RGB triplet assembly and status
// classification for the byte held in the input register.
// ----------------------------------------------------------------------------
module artdmx_parser
    import artdmx_pkg::*;
#(
    parameter int MAX_LIGHTS       = ARTDMX_MAX_LIGHTS,
    parameter int MAX_PACKET_BYTES = ARTDMX_MAX_PACKET_BYTES
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_cfg_we,
    input  logic [4:0] i_cfg_wdata,
    input  logic      i_item_valid,
    input  t_in_item  i_item,
    input  logic      i_out_free,
    output t_step     o_step,
    output t_out_item o_res
);

    localparam int POS_W     = $clog2(MAX_PACKET_BYTES + 1);
    localparam int LD_W      = $clog2(MAX_LIGHTS + 1);
    localparam int LIGHT_CAP = (MAX_LIGHTS < 31) ? MAX_LIGHTS : 31;
    localparam int LIM_W     = $clog2(3 * LIGHT_CAP + 1);
    localparam int CMP_W     = $clog2(3 * (MAX_LIGHTS + 1) + 1);

    localparam int P_FLAGS   = 8;
    localparam int P_OPCODE  = 9;
    localparam int P_VER_HI  = 10;
    localparam int P_VER_LO  = 11;
    localparam int P_LEN_HI  = 16;
    localparam int P_LEN_LO  = 17;
    localparam int P_DATA    = 18;

    localparam logic [1:0] PH_RED   = 2'd0;
    localparam logic [1:0] PH_GREEN = 2'd1;
    localparam logic [1:0] PH_BLUE  = 2'd2;

    logic [4:0]       r_light_count;
    logic [POS_W-1:0] r_pos,     n_pos;
    logic             r_magic,   n_magic;
    logic             r_opgood,  n_opgood;
    logic [7:0]       r_opcode,  n_opcode;
    logic             r_ver,     n_ver;
    logic [7:0]       r_len_hi,  n_len_hi;
    logic [LIM_W-1:0] r_lim,     n_lim;
    logic [1:0]       r_phase,   n_phase;
    logic [7:0]       r_red,     n_red;
    logic [7:0]       r_green,   n_green;
    logic [LD_W-1:0]  r_ld,      n_ld;
    logic             r_second,  n_second;

    logic             in_range;
    logic             dmx_ok;
    logic             has_light;
    logic             eop;
    logic [CMP_W-1:0] need_w;
    logic [15:0]      lights16;
    logic [15:0]      cap16;
    logic [15:0]      full16;
    logic [3:0]       status;
    logic             go;

    // Configuration register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_light_count <= 5'd1;
        end else if (i_cfg_we) begin
            r_light_count <= i_cfg_wdata;
        end
    end

    // Clamp the channel count to three per driven light
    always_comb begin
        lights16 = 16'(r_light_count);
        if (lights16 > 16'(MAX_LIGHTS)) begin
            lights16 = 16'(MAX_LIGHTS);
        end
        cap16  = 16'(lights16 * 16'd3);
        full16 = {r_len_hi, i_item.data_byte};
    end

    // Decode the registered byte against the current packet state
    always_comb begin
        n_pos    = r_pos;
        n_magic  = r_magic;
        n_opgood = r_opgood;
        n_opcode = r_opcode;
        n_ver    = r_ver;
        n_len_hi = r_len_hi;
        n_lim    = r_lim;
        n_phase  = r_phase;
        n_red    = r_red;
        n_green  = r_green;
        n_ld     = r_ld;
        in_range = r_pos < POS_W'(MAX_PACKET_BYTES);
        dmx_ok   = r_magic && r_opgood && (r_opcode == OPC_DMX) && r_ver;
        need_w   = CMP_W'((CMP_W'(r_ld) + CMP_W'(1)) * CMP_W'(3));
        has_light = in_range && (r_pos >= POS_W'(P_DATA)) && (r_phase == PH_BLUE) &&
                    dmx_ok && (need_w <= CMP_W'(r_lim));
        if (in_range) begin
            priority if (r_pos < POS_W'(P_FLAGS)) begin
                if (i_item.data_byte != magic_byte(r_pos[2:0])) begin
                    n_magic = 1'b0;
                end
            end else if (r_pos == POS_W'(P_FLAGS)) begin
                if (i_item.data_byte != 8'h00) begin
                    n_opgood = 1'b0;
                end
            end else if (r_pos == POS_W'(P_OPCODE)) begin
                n_opcode = i_item.data_byte;
            end else if (r_pos == POS_W'(P_VER_HI)) begin
                if (i_item.data_byte != 8'h00) begin
                    n_ver = 1'b0;
                end
            end else if (r_pos == POS_W'(P_VER_LO)) begin
                if (i_item.data_byte != PROTO_VERSION) begin
                    n_ver = 1'b0;
                end
            end else if (r_pos == POS_W'(P_LEN_HI)) begin
                n_len_hi = i_item.data_byte;
            end else if (r_pos == POS_W'(P_LEN_LO)) begin
                n_lim = LIM_W'((full16 > cap16) ? cap16 : full16);
            end else if (r_pos >= POS_W'(P_DATA)) begin
                unique case (r_phase)
                    PH_RED: begin
                        n_red   = i_item.data_byte;
                        n_phase = PH_GREEN;
                    end
                    PH_GREEN: begin
                        n_green = i_item.data_byte;
                        n_phase = PH_BLUE;
                    end
                    default: begin
                        if (r_ld < LD_W'(MAX_LIGHTS)) begin
                            n_ld = LD_W'(r_ld + LD_W'(1));
                        end
                        n_phase = PH_RED;
                    end
                endcase
            end else begin
                n_pos = r_pos;
            end
            n_pos = POS_W'(r_pos + POS_W'(1));
        end
    end

    // Classify the packet from the state after this byte
    always_comb begin
        if (n_pos <= POS_W'(10)) begin
            status = ST_TOO_SHORT;
        end else if (!n_magic) begin
            status = ST_BAD_MAGIC;
        end else if (!n_opgood) begin
            status = ST_BAD_OPCODE;
        end else begin
            unique case (n_opcode)
                OPC_POLL:        status = ST_POLL;
                OPC_TOD_REQUEST: status = ST_TOD_REQUEST;
                OPC_POLL_REPLY:  status = ST_POLL_REPLY;
                OPC_DMX: begin
                    status = (n_ver && (n_pos >= POS_W'(12))) ? ST_DMX_APPLIED
                                                             : ST_WRONG_VER;
                end
                default:         status = ST_UNKNOWN_OPC;
            endcase
        end
    end

    // Pick the result for this cycle; a light update goes ahead of the status
    always_comb begin
        eop      = i_item.end_of_packet;
        o_res    = '0;
        n_second = r_second;
        o_step   = '0;
        go       = 1'b0;
        if (r_second || (!has_light && eop)) begin
            o_res.result_is_status = 1'b1;
            o_res.status_code      = status;
            o_res.last_of_run      = 1'b1;
        end else begin
            o_res.light_index = 4'(r_ld);
            o_res.red_level   = {r_red, 8'h00};
            o_res.green_level = {r_green, 8'h00};
            o_res.blue_level  = {i_item.data_byte, 8'h00};
            o_res.last_of_run = !eop;
        end
        if (i_item_valid) begin
            if (has_light || eop) begin
                go          = i_out_free;
                o_step.load = i_out_free;
            end else begin
                go = 1'b1;
            end
        end
        if (go) begin
            if (has_light && eop && !r_second) begin
                n_second = 1'b1;
            end else begin
                n_second       = 1'b0;
                o_step.consume = 1'b1;
            end
        end
    end

    // Advance packet state; end of packet starts the next one clean
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (o_step.consume && eop)) begin
            r_pos    <= '0;
            r_magic  <= 1'b1;
            r_opgood <= 1'b1;
            r_opcode <= '0;
            r_ver    <= 1'b1;
            r_len_hi <= '0;
            r_lim    <= '0;
            r_phase  <= PH_RED;
            r_red    <= '0;
            r_green  <= '0;
            r_ld     <= '0;
        end else if (o_step.consume) begin
            r_pos    <= n_pos;
            r_magic  <= n_magic;
            r_opgood <= n_opgood;
            r_opcode <= n_opcode;
            r_ver    <= n_ver;
            r_len_hi <= n_len_hi;
            r_lim    <= n_lim;
            r_phase  <= n_phase;
            r_red    <= n_red;
            r_green  <= n_green;
            r_ld     <= n_ld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_second <= 1'b0;
        end else begin
            r_second <= n_second;
        end
    end

    // The status half of a split byte waits only on a held end-of-packet byte
    a_second_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_second |-> (i_item_valid && i_item.end_of_packet))
        else $error("second result pending without an end-of-packet byte");

    a_second_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_second && o_step.consume) |=> !r_second)
        else $error("second result not retired after consume");

    a_phase_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase != 2'd3)
        else $error("triplet phase out of range");

    a_ld_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ld <= LD_W'(MAX_LIGHTS))
        else $error("light counter above its limit");

endmodule

/* hw/rtl/artdmx_out_reg.sv */
// ----------------------------------------------------------------------------
// artdmx_out_reg
// Result register on the output channel; holds a result until it is taken.
// ----------------------------------------------------------------------------
module artdmx_out_reg
    import artdmx_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_load,
    input  t_out_item i_res,
    output logic      o_free,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_item o_out_data
);

    logic      r_valid;
    t_out_item r_data;

    // Free when empty or when the held transaction completes now
    assign o_free = !r_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_free) begin
            r_valid <= i_load;
        end
    end

    // Hold the payload while stalled
    always_ff @(posedge i_clk) begin
        if (o_free && i_load) begin
            r_data <= i_res;
        end
    end

    assign o_out_valid = r_valid;
    assign o_out_data  = r_data;

endmodule

/* hw/rtl/artdmx_packet_to_rgb_lights_unit.sv */
// ----------------------------------------------------------------------------
// artdmx_packet_to_rgb_lights_unit
// ArtDmx receiver: checks a byte stream as Art-Net and emits RGB light
// updates and one status result per packet.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_in_valid / o_in_ready / i_in_data) takes one UDP payload
//   byte per transaction, end_of_packet set on the last byte of a datagram.
//   Output channel (o_out_valid / i_out_ready / o_out_data) gives light
//   updates (one per complete RGB triplet inside the clamped channel count)
//   and a status result after each packet's last byte.
//   i_cfg_we / i_cfg_wdata write the light count; write only while idle.
// Path: a byte is registered in the input register at acceptance, parsed
//   from there and its result is registered in the output register.
// Throughput: one byte per cycle unless the output stalls. A packet's last
//   byte that also completes an emitted triplet holds the parser for both
//   results, since the single output register takes one result per cycle.
// Reset: light count returns to 1, packet state is cleared, both valids low.
// Stall: the output register holds its result; the next byte that has a
//   result waits in the input register, o_in_ready low till the output frees.
// ----------------------------------------------------------------------------
module artdmx_packet_to_rgb_lights_unit
    import artdmx_pkg::*;
#(
    parameter int MAX_LIGHTS       = ARTDMX_MAX_LIGHTS,
    parameter int MAX_PACKET_BYTES = ARTDMX_MAX_PACKET_BYTES
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic [4:0] i_cfg_wdata,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  t_in_item   i_in_data,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output t_out_item  o_out_data
);

    logic      r_in_valid;
    t_in_item  r_in_data;
    t_step     step;
    t_out_item res;
    logic      out_free;

    // Take a new byte when the register is empty or its byte retires now
    assign o_in_ready = !r_in_valid || step.consume;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in_data <= i_in_data;
        end
    end

    // Parse the held byte
    artdmx_parser #(
        .MAX_LIGHTS       (MAX_LIGHTS),
        .MAX_PACKET_BYTES (MAX_PACKET_BYTES)
    ) u_parser (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_wdata  (i_cfg_wdata),
        .i_item_valid (r_in_valid),
        .i_item       (r_in_data),
        .i_out_free   (out_free),
        .o_step       (step),
        .o_res        (res)
    );

    // Register results toward the receiver
    artdmx_out_reg u_out_reg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_load      (step.load),
        .i_res       (res),
        .o_free      (out_free),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

endmodule

/* tb/sv/tb.sv */
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the ArtDmx receiver with RGB light outputs.
// Streams Art-Net packets byte by byte through the input channel, predicts the
// light updates and the per-packet status in step with each accepted byte,
// and compares every output transaction field by field. A directed table of
// packets covers each status code, header corner and size limit. Random
// packets follow under several light counts, with bursty input and a
// receiver that stalls in changing patterns.
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import artdmx_pkg::*;

    // Byte offsets inside the Art-Net header
    localparam int POS_PAD      = 8;
    localparam int POS_OPCODE   = 9;
    localparam int POS_VER_HI   = 10;
    localparam int POS_VER_LO   = 11;
    localparam int POS_COUNT_HI = 16;
    localparam int POS_COUNT_LO = 17;
    localparam int POS_DATA     = 18;
    localparam int SHORT_MAX    = 10;
    localparam int VER_END      = 12;

    localparam logic [63:0] ART_ID = {"Art-Net", 8'h00};

    // Payload fill patterns; noise also scrambles the header
    localparam logic [1:0] FILL_RANDOM = 2'd0;
    localparam logic [1:0] FILL_ZERO   = 2'd1;
    localparam logic [1:0] FILL_ONES   = 2'd2;
    localparam logic [1:0] FILL_NOISE  = 2'd3;

    // Receiver stall patterns
    localparam int RX_OPEN   = 0;
    localparam int RX_COIN   = 1;
    localparam int RX_SPARSE = 2;
    localparam int RX_LONG   = 3;

    localparam int RAND_BYTES   = 132;
    localparam int NUM_PHASES   = 6;
    localparam int DRAIN_CYCLES = 8;

    typedef struct packed {
        logic [7:0]  opcode;
        logic [15:0] version;      // bytes 10..11
        logic [15:0] chan_count;   // bytes 16..17
        logic [10:0] length;
        logic        corrupt_id;   // flip a bit in the ID text
        logic        corrupt_pad;  // nonzero byte after the ID text
        logic [1:0]  fill;
        logic        typed;        // status below is the expected one
        logic [3:0]  status;
    } t_pkt_row;

    // Directed packets, walked with the reset light count of 1
    localparam t_pkt_row DIR_ROWS [19] = '{
        '{OPC_DMX,         16'd14,     16'd3,      11'd21,   1'b0, 1'b0, FILL_RANDOM,
          1'b1, ST_DMX_APPLIED},
        '{OPC_DMX,         16'd14,     16'd3,      11'd1,    1'b0, 1'b0, FILL_RANDOM,
          1'b1, ST_TOO_SHORT},
        '{OPC_DMX,         16'd14,     16'd3,      11'd10,   1'b0, 1'b0, FILL_RANDOM,
          1'b1, ST_TOO_SHORT},
        '{OPC_POLL,        16'd14,     16'd0,      11'd11,   1'b0, 1'b0, FILL_RANDOM,
          1'b1, ST_POLL},
        '{OPC_DMX,         16'd14,     16'd3,      11'd11,   1'b0, 1'b0, FILL_RANDOM,
          1'b1, ST_WRONG_VER},
        '{OPC_DMX,         16'd14,     16'd3,      11'd12,   1'b0, 1'b0, FILL_RANDOM,
          1'b1, ST_DMX_APPLIED},
        '{OPC_DMX,         16'd14,     16'd3,      11'd20,   1'b1, 1'b0, FILL_RANDOM,
          1'b1, ST_BAD_MAGIC},
        '{OPC_DMX,         16'd14,     16'd3,      11'd20,   1'b0, 1'b1, FILL_RANDOM,
          1'b1, ST_BAD_OPCODE},
        '{OPC_DMX,         16'd14,     16'd3,      11'd5,    1'b1, 1'b1, FILL_RANDOM,
          1'b1, ST_TOO_SHORT},
        '{OPC_POLL,        16'd14,     16'd0,      11'd11,   1'b1, 1'b1, FILL_RANDOM,
          1'b1, ST_BAD_MAGIC},
        '{OPC_TOD_REQUEST, 16'd14,     16'd0,      11'd14,   1'b0, 1'b0, FILL_RANDOM,
          1'b1, ST_TOD_REQUEST},
        '{OPC_POLL_REPLY,  16'd14,     16'd3,      11'd24,   1'b0, 1'b0, FILL_RANDOM,
          1'b1, ST_POLL_REPLY},
        '{8'hFF,           16'd14,     16'd3,      11'd18,   1'b0, 1'b0, FILL_ONES,
          1'b1, ST_UNKNOWN_OPC},
        '{8'h00,           16'd14,     16'd3,      11'd12,   1'b0, 1'b0, FILL_ZERO,
          1'b1, ST_UNKNOWN_OPC},
        '{OPC_DMX,         16'd13,     16'd3,      11'd24,   1'b0, 1'b0, FILL_RANDOM,
          1'b1, ST_WRONG_VER},
        '{OPC_DMX,         16'h010E,   16'd3,      11'd24,   1'b0, 1'b0, FILL_RANDOM,
          1'b1, ST_WRONG_VER},
        '{OPC_DMX,         16'd14,     16'hFFFF,   11'd26,   1'b0, 1'b0, FILL_ONES,
          1'b1, ST_DMX_APPLIED},
        '{OPC_DMX,         16'd14,     16'd0,      11'd24,   1'b0, 1'b0, FILL_ZERO,
          1'b1, ST_DMX_APPLIED},
        '{OPC_DMX,         16'd14,     16'd3,      11'd1030, 1'b0, 1'b0, FILL_RANDOM,
          1'b0, ST_DMX_APPLIED}
    };

    localparam logic [4:0] CFG_PLAN [NUM_PHASES - 1] = '{5'd16, 5'd0, 5'd31, 5'd1, 5'd17};

    logic       i_clk       = 1'b0;
    logic       i_rst_n     = 1'b0;
    logic       i_cfg_we    = 1'b0;
    logic [4:0] i_cfg_wdata = '0;
    logic       i_in_valid  = 1'b0;
    logic       o_in_ready;
    t_in_item   i_in_data   = '0;
    logic       o_out_valid;
    logic       i_out_ready = 1'b0;
    t_out_item  o_out_data;

    artdmx_packet_to_rgb_lights_unit uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

    always #2 i_clk = ~i_clk;

    // Predicted light updates and statuses still to come out
    t_out_item   due_results[$];
    logic [7:0]  pkt_bytes[$];
    int unsigned fails = 0;
    int unsigned bytes_sent = 0;

    // Receiver-side copy of the parser state
    int unsigned light_cnt = 1;
    int unsigned pkt_pos;
    logic        id_ok;
    logic        pad_ok;
    logic        ver_ok;
    logic [7:0]  opcode_q;
    int unsigned chan_limit;
    int unsigned triplet_step;
    logic [7:0]  red_q;
    logic [7:0]  green_q;
    int unsigned lit_count;

    // Clear the packet state at reset and after each packet end
    function automatic void clear_packet();
        pkt_pos      = 0;
        id_ok        = 1'b1;
        pad_ok       = 1'b1;
        ver_ok       = 1'b1;
        opcode_q     = '0;
        chan_limit   = 0;
        triplet_step = 0;
        red_q        = '0;
        green_q      = '0;
        lit_count    = 0;
    endfunction

    function automatic logic [3:0] packet_status();
        if (pkt_pos <= SHORT_MAX) return ST_TOO_SHORT;
        if (!id_ok) return ST_BAD_MAGIC;
        if (!pad_ok) return ST_BAD_OPCODE;
        case (opcode_q)
            OPC_POLL:        return ST_POLL;
            OPC_TOD_REQUEST: return ST_TOD_REQUEST;
            OPC_POLL_REPLY:  return ST_POLL_REPLY;
            OPC_DMX:         return (ver_ok && pkt_pos >= VER_END) ? ST_DMX_APPLIED
                                                                    : ST_WRONG_VER;
            default:         return ST_UNKNOWN_OPC;
        endcase
    endfunction

    // Advance the parser by one accepted byte and queue what it produces
    function automatic void decode_byte(t_in_item it, logic typed, logic [3:0] typed_status);
        t_out_item   upd;
        t_out_item   st;
        logic        have_upd;
        int unsigned lights;
        logic [7:0]  b;

        b        = it.data_byte;
        have_upd = 1'b0;
        upd      = '0;
        st       = '0;
        if (pkt_pos < ARTDMX_MAX_PACKET_BYTES) begin
            if (pkt_pos < POS_PAD) begin
                if (b != ART_ID[63 - 8 * pkt_pos -: 8]) id_ok = 1'b0;
            end else if (pkt_pos == POS_PAD) begin
                if (b != 8'h00) pad_ok = 1'b0;
            end else if (pkt_pos == POS_OPCODE) begin
                opcode_q = b;
            end else if (pkt_pos == POS_VER_HI) begin
                if (b != 8'h00) ver_ok = 1'b0;
            end else if (pkt_pos == POS_VER_LO) begin
                if (b != PROTO_VERSION) ver_ok = 1'b0;
            end else if (pkt_pos == POS_COUNT_HI) begin
                chan_limit = {b, 8'h00};
            end else if (pkt_pos == POS_COUNT_LO) begin
                lights     = (light_cnt > ARTDMX_MAX_LIGHTS) ? ARTDMX_MAX_LIGHTS : light_cnt;
                chan_limit = chan_limit | b;
                if (chan_limit > 3 * lights) chan_limit = 3 * lights;
            end else if (pkt_pos >= POS_DATA) begin
                if (triplet_step == 0) begin
                    red_q        = b;
                    triplet_step = 1;
                end else if (triplet_step == 1) begin
                    green_q      = b;
                    triplet_step = 2;
                end else begin
                    if (id_ok && pad_ok && opcode_q == OPC_DMX && ver_ok &&
                        lit_count < chan_limit / 3) begin
                        have_upd          = 1'b1;
                        upd.light_index   = lit_count[3:0];
                        upd.red_level     = {red_q, 8'h00};
                        upd.green_level   = {green_q, 8'h00};
                        upd.blue_level    = {b, 8'h00};
                    end
                    if (lit_count < ARTDMX_MAX_LIGHTS) lit_count++;
                    triplet_step = 0;
                end
            end
            pkt_pos++;
        end

        if (have_upd) begin
            upd.last_of_run = !it.end_of_packet;
            due_results.push_back(upd);
        end
        if (it.end_of_packet) begin
            st.result_is_status = 1'b1;
            st.status_code      = typed ? typed_status : packet_status();
            st.last_of_run      = 1'b1;
            due_results.push_back(st);
            clear_packet();
        end
    endfunction

    // Lay out the bytes of one packet from its row
    function automatic void build_packet(t_pkt_row row);
        logic [7:0] b;
        int         k;
        int         pick;

        pkt_bytes.delete();
        for (k = 0; k < row.length; k++) begin
            if (row.fill == FILL_NOISE)  b = 8'($urandom);
            else if (k < POS_PAD)        b = ART_ID[63 - 8 * k -: 8];
            else if (k == POS_PAD)       b = 8'h00;
            else if (k == POS_OPCODE)    b = row.opcode;
            else if (k == POS_VER_HI)    b = row.version[15:8];
            else if (k == POS_VER_LO)    b = row.version[7:0];
            else if (k == POS_COUNT_HI)  b = row.chan_count[15:8];
            else if (k == POS_COUNT_LO)  b = row.chan_count[7:0];
            else if (k < POS_DATA)       b = 8'($urandom);
            else if (row.fill == FILL_ZERO) b = 8'h00;
            else if (row.fill == FILL_ONES) b = 8'hFF;
            else                         b = 8'($urandom);
            pkt_bytes.push_back(b);
        end
        if (row.corrupt_id) begin
            pick = $urandom_range(0, (row.length > POS_PAD) ? POS_PAD - 1 : row.length - 1);
            pkt_bytes[pick] = pkt_bytes[pick] ^ (8'h01 << $urandom_range(0, 7));
        end
        if (row.corrupt_pad && row.length > POS_PAD)
            pkt_bytes[POS_PAD] = 8'($urandom_range(1, 255));
    endfunction

    // Mostly well-formed ArtDmx, then other opcodes, broken headers and noise
    function automatic t_pkt_row random_row();
        t_pkt_row    row;
        int unsigned roll;
        int unsigned eff;

        eff  = (light_cnt > ARTDMX_MAX_LIGHTS) ? ARTDMX_MAX_LIGHTS : light_cnt;
        roll = $urandom_range(0, 99);
        row  = '0;
        row.opcode     = OPC_DMX;
        row.version    = 16'(PROTO_VERSION);
        row.chan_count = ($urandom_range(0, 9) < 7) ? 16'($urandom_range(0, 54))
                                                    : 16'($urandom);
        row.fill       = 2'($urandom_range(0, 2));
        row.length     = 11'(POS_DATA + $urandom_range(0, 3 * eff + 4));
        if (roll < 8) begin
            row.length = 11'($urandom_range(1, 20));
        end else if (roll < 65) begin
            // well-formed ArtDmx as set up above
        end else if (roll < 75) begin
            case ($urandom_range(0, 3))
                0:       row.opcode = OPC_POLL;
                1:       row.opcode = OPC_POLL_REPLY;
                2:       row.opcode = OPC_TOD_REQUEST;
                default: row.opcode = 8'($urandom);
            endcase
            row.length = 11'($urandom_range(11, 40));
        end else if (roll < 88) begin
            case ($urandom_range(0, 3))
                0:       row.corrupt_id  = 1'b1;
                1:       row.corrupt_pad = 1'b1;
                2:       row.version     = {8'h00, 8'($urandom)};
                default: row.version     = 16'($urandom);
            endcase
            row.length = 11'($urandom_range(POS_VER_HI, 40));
        end else begin
            row.fill   = FILL_NOISE;
            row.length = 11'($urandom_range(1, 40));
        end
        return row;
    endfunction

    // Sender bursts: a burst of transactions, then a gap with valid low
    int unsigned burst_left = 0;

    task automatic push_byte(t_in_item it, logic typed, logic [3:0] typed_status);
        int unsigned gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 40);
            gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap != 0) begin
                i_in_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        i_in_valid <= 1'b1;
        i_in_data  <= it;
        do @(posedge i_clk); while (!o_in_ready);
        decode_byte(it, typed, typed_status);
        burst_left--;
        bytes_sent++;
    endtask

    task automatic send_packet(t_pkt_row row);
        t_in_item it;
        int       k;
        build_packet(row);
        for (k = 0; k < pkt_bytes.size(); k++) begin
            it.data_byte     = pkt_bytes[k];
            it.end_of_packet = (k == pkt_bytes.size() - 1);
            push_byte(it, row.typed, row.status);
        end
    endtask

    // Drop valid and let every expected result come out
    task automatic wait_drained();
        i_in_valid <= 1'b0;
        burst_left = 0;
        while (due_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // Receiver: periodically pick a stall pattern at random
    int unsigned rx_tick = 0;
    int unsigned rx_mode = RX_OPEN;

    always @(posedge i_clk) begin
        rx_tick++;
        if (rx_tick % 128 == 0) rx_mode = $urandom_range(RX_OPEN, RX_LONG);
        case (rx_mode)
            RX_OPEN:   i_out_ready <= 1'b1;
            RX_COIN:   i_out_ready <= 1'($urandom_range(0, 1));
            RX_SPARSE: i_out_ready <= (rx_tick % 4 == 0);
            default:   i_out_ready <= (rx_tick % 32 >= 20);
        endcase
    end

    task automatic check_field(string name, int unsigned want, int unsigned got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            fails++;
        end
    endtask

    // Compare each output transaction against the oldest prediction
    always @(posedge i_clk) begin
        t_out_item want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (due_results.size() == 0) begin
                $error("unexpected result %h with nothing pending", o_out_data);
                fails++;
            end else begin
                want = due_results.pop_front();
                check_field("result_is_status", want.result_is_status,
                            o_out_data.result_is_status);
                check_field("status_code", want.status_code, o_out_data.status_code);
                check_field("light_index", want.light_index, o_out_data.light_index);
                check_field("red_level", want.red_level, o_out_data.red_level);
                check_field("green_level", want.green_level, o_out_data.green_level);
                check_field("blue_level", want.blue_level, o_out_data.blue_level);
                check_field("last_of_run", want.last_of_run, o_out_data.last_of_run);
            end
        end
    end

    // Main sequence: reset, directed table, then random phases
    initial begin
        int          i;
        int          ph;
        int unsigned quota;
        logic [4:0]  cfg;

        clear_packet();
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (i = 0; i < $size(DIR_ROWS); i++) send_packet(DIR_ROWS[i]);

        for (ph = 0; ph < NUM_PHASES; ph++) begin
            wait_drained();
            cfg = (ph == NUM_PHASES - 1) ? 5'($urandom_range(2, 15)) : CFG_PLAN[ph];
            i_cfg_we    <= 1'b1;
            i_cfg_wdata <= cfg;
            @(posedge i_clk);
            i_cfg_we  <= 1'b0;
            light_cnt = cfg;
            quota = bytes_sent + RAND_BYTES / NUM_PHASES;
            while (bytes_sent < quota) send_packet(random_row());
        end
        wait_drained();

        if (fails == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

    // Hang guard
    initial begin
        #2_000_000;
        $display("TEST FAILED");
        $finish;
    end

endmodule
